>>> rtl/rts_pkg.sv
// Package for the record table: operation and status codes, FSM states,
// controller/datapath command and status structs. No dependencies.
package rts_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam int NAME_W  = 64;
    localparam int COORD_W = 16;
    localparam int WORTH_W = 32;
    localparam int KIND_W  = 3;
    localparam int SLOT_W  = 4;

    localparam logic [KIND_W-1:0] OP_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] OP_DELETE = 3'd1;
    localparam logic [KIND_W-1:0] OP_FIND   = 3'd2;
    localparam logic [KIND_W-1:0] OP_SORT   = 3'd3;
    localparam logic [KIND_W-1:0] OP_MAX    = 3'd4;
    localparam logic [KIND_W-1:0] OP_DUMP   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,    // append: write input record at fill
        S_SCAN_RD,   // issue read of entry at scan index
        S_SCAN_CHK,  // read data valid, compare
        S_SHIFT_RD,  // delete: read entry j+1
        S_SHIFT_WR,  // delete: write it to j
        S_SORT_RDI,  // sort: read entry i
        S_SORT_RDJ,  // sort: read entry j
        S_SORT_CHK,  // sort: compare, maybe write j with held i
        S_SORT_WRI,  // sort: write held record into i
        S_OUT_RD,    // read result entry
        S_OUT_LD,    // load output register
        S_OUT        // result held in output register
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;      // capture input transfer
        logic rd_en;
        logic wr_en;
        logic wr_sel_in;    // write data from input item
        logic wr_sel_hold;  // write data from hold register (else read data)
        logic hold_rd;      // copy read data to hold register
        logic best_rd;      // copy read data to best register
        logic out_load;     // load output register
        logic out_rec;      // output carries read record
        logic [1:0] status;
        logic final_flag;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic name_eq;
        logic pos_eq;
        logic rd_gt_best;   // read worth > best worth
        logic hold_lt_rd;   // hold worth < read worth
    } stat_t;

endpackage

>>> rtl/rts_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> rtl/rts_datapath.sv
// Record table datapath: record RAM, input/hold/best registers, comparators,
// output register. Depends on rts_pkg and rts_ram.
module rts_datapath
    import rts_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int REC_W = NAME_W + 2*COORD_W + WORTH_W
) (
    input  logic                      clk,
    input  cmd_t                      cmd,
    input  logic [AW-1:0]             rd_addr,
    input  logic [AW-1:0]             wr_addr,
    input  logic [AW:0]               out_slot,
    input  logic [NAME_W-1:0]         in_name,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [WORTH_W-1:0] in_worth,
    output stat_t                     stat,
    output logic [1:0]                status,
    output logic [NAME_W-1:0]         out_name,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [WORTH_W-1:0] out_worth,
    output logic [SLOT_W-1:0]         slot,
    output logic                      final_res
);
    localparam int KEEP_W = 8*NAME_BYTES;

    logic [REC_W-1:0] in_rec_reg, hold_reg, best_reg, rd_rec, wr_rec;
    logic [REC_W-1:0] out_rec_reg;
    logic [1:0]       status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic             final_reg;
    logic [NAME_W-1:0] key_masked;

    // name key keeps only the low NAME_BYTES bytes
    always_comb
    begin
        key_masked = '0;
        key_masked[KEEP_W-1:0] = in_name[KEEP_W-1:0];
    end

    // record layout: {name, x, y, worth}
    always_comb
    begin
        if (cmd.wr_sel_in)
        begin
            wr_rec = in_rec_reg;
        end
        else if (cmd.wr_sel_hold)
        begin
            wr_rec = hold_reg;
        end
        else
        begin
            wr_rec = rd_rec;
        end
    end

    rts_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rec)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_rec_reg <= {key_masked, in_x, in_y, in_worth};
        end
        if (cmd.hold_rd)
        begin
            hold_reg <= rd_rec;
        end
        if (cmd.best_rd)
        begin
            best_reg <= rd_rec;
        end
        if (cmd.out_load)
        begin
            out_rec_reg <= cmd.out_rec ? rd_rec : '0;
            status_reg  <= cmd.status;
            slot_reg    <= SLOT_W'(out_slot);
            final_reg   <= cmd.final_flag;
        end
    end

    // comparators
    always_comb
    begin
        stat.name_eq = rd_rec[REC_W-1 -: NAME_W] == in_rec_reg[REC_W-1 -: NAME_W];
        stat.pos_eq  = rd_rec[WORTH_W +: 2*COORD_W] == in_rec_reg[WORTH_W +: 2*COORD_W];
        stat.rd_gt_best = $signed(rd_rec[WORTH_W-1:0]) > $signed(best_reg[WORTH_W-1:0]);
        stat.hold_lt_rd = $signed(hold_reg[WORTH_W-1:0]) < $signed(rd_rec[WORTH_W-1:0]);
    end

    assign out_name  = out_rec_reg[REC_W-1 -: NAME_W];
    assign out_x     = out_rec_reg[WORTH_W+COORD_W +: COORD_W];
    assign out_y     = out_rec_reg[WORTH_W +: COORD_W];
    assign out_worth = out_rec_reg[WORTH_W-1:0];
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign final_res = final_reg;
endmodule

>>> rtl/rts_ctrl.sv
// Record table controller: operation sequencer, indexes and fill count.
// Depends on rts_pkg.
module rts_ctrl
    import rts_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] in_kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  stat_t             stat,
    output cmd_t              cmd,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     wr_addr,
    output logic [AW:0]       out_slot,
    output logic [AW:0]       fill
);
    localparam logic [AW:0] CAP = (AW+1)'(CAPACITY);
    localparam logic [AW:0] ONE = (AW+1)'(1);

    state_t state_reg, state_next;
    logic [KIND_W-1:0] op_reg, op_next;
    logic [AW:0] fill_reg, fill_next;
    logic [AW:0] i_reg, i_next, j_reg, j_next, best_reg, best_next;
    logic [AW:0] slot_reg, slot_next;
    logic        held_reg, held_next;          // sort: hold has entry i
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_rec_reg, res_rec_next;    // result carries a record
    logic        res_last_reg, res_last_next;  // last result of the operation
    logic [AW:0] i_inc, j_inc, slot_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            op_reg         <= OP_APPEND;
            i_reg          <= '0;
            j_reg          <= '0;
            best_reg       <= '0;
            slot_reg       <= '0;
            held_reg       <= 1'b0;
            res_status_reg <= ST_OK;
            res_rec_reg    <= 1'b0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            op_reg         <= op_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            best_reg       <= best_next;
            slot_reg       <= slot_next;
            held_reg       <= held_next;
            res_status_reg <= res_status_next;
            res_rec_reg    <= res_rec_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign fill      = fill_reg;
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_slot  = slot_reg;

    // next state and commands
    always_comb
    begin
        i_inc           = i_reg + ONE;
        j_inc           = j_reg + ONE;
        slot_inc        = slot_reg + ONE;
        state_next      = state_reg;
        op_next         = op_reg;
        fill_next       = fill_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        best_next       = best_reg;
        slot_next       = slot_reg;
        held_next       = held_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        res_last_next   = res_last_reg;
        cmd             = '0;
        rd_addr         = i_reg[AW-1:0];
        wr_addr         = i_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in     = 1'b1;
                    op_next         = in_kind;
                    i_next          = '0;
                    slot_next       = '0;
                    res_status_next = ST_OK;
                    res_rec_next    = 1'b0;
                    res_last_next   = 1'b1;
                    unique case (in_kind) inside
                        OP_APPEND:
                        begin
                            if (fill_reg == CAP)
                            begin
                                res_status_next = ST_FULL;
                                state_next = S_OUT_RD;
                            end
                            else
                            begin
                                state_next = S_APPEND;
                            end
                        end
                        OP_DELETE, OP_FIND:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_NONE;
                                state_next = S_OUT_RD;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_SORT:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next = S_OUT_RD;
                            end
                            else if (fill_reg == ONE)
                            begin
                                state_next = S_OUT_RD;
                            end
                            else
                            begin
                                state_next = S_SORT_RDI;
                            end
                        end
                        OP_MAX:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next = S_OUT_RD;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                res_rec_next  = 1'b1;
                                res_last_next = fill_reg == ONE;
                            end
                            state_next = S_OUT_RD;
                        end
                        default:
                        begin
                            // unused kinds are dropped
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPEND:
            begin
                wr_addr = fill_reg[AW-1:0];
                cmd.wr_en = 1'b1;
                cmd.wr_sel_in = 1'b1;
                fill_next = fill_reg + ONE;
                slot_next = fill_reg;
                state_next = S_OUT_RD;
            end
            S_SCAN_RD:
            begin
                cmd.rd_en = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                i_next = i_inc;
                state_next = S_SCAN_RD;
                if (op_reg == OP_DELETE && stat.name_eq)
                begin
                    slot_next = i_reg;
                    j_next = i_reg;
                    state_next = S_SHIFT_RD;
                end
                else if (op_reg == OP_FIND && stat.pos_eq)
                begin
                    slot_next = i_reg;
                    res_rec_next = 1'b1;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    // max keeps the first of equal values
                    if (op_reg == OP_MAX && (i_reg == '0 || stat.rd_gt_best))
                    begin
                        cmd.best_rd = 1'b1;
                        best_next = i_reg;
                    end
                    if (i_inc == fill_reg)
                    begin
                        state_next = S_OUT_RD;
                        if (op_reg == OP_MAX)
                        begin
                            slot_next = best_next;
                            res_rec_next = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_NONE;
                        end
                    end
                end
            end
            S_SHIFT_RD:
            begin
                if (j_inc >= fill_reg)
                begin
                    fill_next = fill_reg - ONE;
                    state_next = S_OUT_RD;
                end
                else
                begin
                    rd_addr = j_inc[AW-1:0];
                    cmd.rd_en = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                wr_addr = j_reg[AW-1:0];
                cmd.wr_en = 1'b1;
                j_next = j_inc;
                state_next = S_SHIFT_RD;
            end
            S_SORT_RDI:
            begin
                cmd.rd_en = 1'b1;
                j_next = i_inc;
                held_next = 1'b0;
                state_next = S_SORT_RDJ;
            end
            S_SORT_RDJ:
            begin
                // hold takes entry i right after S_SORT_RDI
                if (!held_reg)
                begin
                    cmd.hold_rd = 1'b1;
                    held_next = 1'b1;
                end
                rd_addr = j_reg[AW-1:0];
                cmd.rd_en = 1'b1;
                state_next = S_SORT_CHK;
            end
            S_SORT_CHK:
            begin
                // hold is the current value at i; read data is entry j
                if (stat.hold_lt_rd)
                begin
                    wr_addr = j_reg[AW-1:0];
                    cmd.wr_en = 1'b1;
                    cmd.wr_sel_hold = 1'b1;
                    cmd.hold_rd = 1'b1;
                end
                j_next = j_inc;
                state_next = (j_inc == fill_reg) ? S_SORT_WRI : S_SORT_RDJ;
            end
            S_SORT_WRI:
            begin
                cmd.wr_en = 1'b1;
                cmd.wr_sel_hold = 1'b1;
                i_next = i_inc;
                state_next = ((i_inc + ONE) == fill_reg) ? S_OUT_RD : S_SORT_RDI;
            end
            S_OUT_RD:
            begin
                rd_addr = slot_reg[AW-1:0];
                cmd.rd_en = 1'b1;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_rec = res_rec_reg;
                cmd.status = res_status_reg;
                cmd.final_flag = res_last_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (op_reg == OP_DUMP && !res_last_reg)
                    begin
                        // dump: next record after each result transfer
                        slot_next = slot_inc;
                        res_last_next = (slot_inc + ONE) == fill_reg;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/record_table_sort_search_top.sv
// Record table top: joins controller and datapath, stream ports.
// Depends on rts_pkg, rts_ctrl, rts_datapath, rts_ram.
// ---------------------------------------------------------------------------
// Fixed-capacity record table (CAPACITY records of name, x, y, value) with
// append, delete-by-name, find-by-coordinates, exchange sort, max and dump.
// One item is taken at a time; the record store is a single RAM with one
// read and one write port, and find, max and delete walk it entry by entry
// with a read and then a compare. Append writes the record at the fill
// index; a full-table append and every empty-table case go straight to the
// result; delete moves each later entry down by a read and a write; sort on
// n >= 2 records compares the held entry i with each later entry j. Dump
// gives its records one by one, reading the next after each result
// transfer. Results leave through an output register and input is taken
// again from the cycle after the final result transfer.
// ---------------------------------------------------------------------------
module record_table_sort_search_top
    import rts_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // rec_name[63:0], pos_x[79:64], pos_y[95:80], worth[127:96]
    input  logic [2:0]   s_tuser,   // kind[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // status[1:0], out_name[65:2], out_x[81:66],
                                    // out_y[97:82], out_worth[129:98], slot[133:130], 0
    output logic         m_tlast    // final_res
);
    localparam int AW = $clog2(CAPACITY);

    cmd_t  cmd;
    stat_t stat;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [AW:0]   out_slot, fill;
    logic [1:0]    status;
    logic [NAME_W-1:0] out_name;
    logic signed [COORD_W-1:0] out_x, out_y;
    logic signed [WORTH_W-1:0] out_worth;
    logic [SLOT_W-1:0] slot;
    logic          final_res;

    rts_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .out_slot  (out_slot),
        .fill      (fill)
    );

    rts_datapath #(.CAPACITY(CAPACITY), .NAME_BYTES(NAME_BYTES)) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .out_slot  (out_slot),
        .in_name   (s_tdata[63:0]),
        .in_x      (s_tdata[79:64]),
        .in_y      (s_tdata[95:80]),
        .in_worth  (s_tdata[127:96]),
        .stat      (stat),
        .status    (status),
        .out_name  (out_name),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_worth (out_worth),
        .slot      (slot),
        .final_res (final_res)
    );

    assign m_tdata = {2'b00, slot, out_worth, out_y, out_x, out_name, status};
    assign m_tlast = final_res;

    // no input is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    // fill count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
                     fill <= (AW+1)'(CAPACITY))
        else $error("fill count overflow");
    // fill changes only by one step
    assert property (@(posedge clk) disable iff (!rst_n)
                     !$stable(fill) |-> (fill == $past(fill) + 1'b1
                                        || fill == $past(fill) - 1'b1))
        else $error("fill count jumped");
endmodule
